### design/brle_pkg.sv
// Package of the byte run-length encoder: constants, item types and sequencer states.
package brle_pkg;

  // Default configuration of the encoder.
  localparam int unsigned MAX_RUN_DEF = 128;
  localparam int unsigned BPW_DEF     = 8;

  // Literal memory geometry.
  localparam int unsigned LIT_DEPTH = 128;
  localparam int unsigned LIT_AW    = 7;

  // Header flag bits.
  localparam logic [7:0] RPT_FLAG = 8'h80;
  localparam logic [7:0] LIT_FLAG = 8'h00;

  // Input item: one byte of the stream.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       stream_last;
  } brle_in_t;

  // Result item: one packed word of encoded bytes.
  typedef struct packed {
    logic [63:0] packed_bytes;
    logic [3:0]  byte_count;
    logic        group_last;
    logic        stream_end;
  } brle_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_RPT_HDR,
    ST_RPT_VAL,
    ST_FINAL,
    ST_FL_HDR,
    ST_FL_DATA,
    ST_DONE
  } brle_state_e;

endpackage

### design/brle_stream_if.sv
// Valid/ready stream channel that carries one item of type T.
interface brle_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/byte_run_length_encoder.sv
// Top level of the byte run-length encoder with its literal memory and word packer.
//
// The encoder splits a byte stream into runs of equal bytes of at most MAX_RUN, emits runs of
// two or more as 0x80|(n-1) and the value, and gathers single bytes in a 128-entry literal
// memory that is flushed as the header (n-1) and the stored bytes. Encoded bytes leave packed
// in words of BYTES_PER_WORD bytes, low byte first; the last word of each input item carries
// group_last, and the last word of the stream also carries stream_end. An input item that
// only extends a run is taken in ST_IDLE alone; one that opens a run, whether or not it closes
// a single-byte run, also passes through ST_CLOSE. A repeat pushes its header byte and then its
// value byte. A literal flush of n bytes pushes the header, then the stored bytes, which the
// literal memory gives one byte a cycle through its single registered read port while the
// packer takes them, and then resumes the step that called for the flush. The final item of a
// stream closes its last run in a second pass and then checks for pending literals. The last
// word of an item that produced output is sent from ST_DONE. Output stalls can hold any of
// these steps. Output words are held in a register, so the block may take the next item while
// a finished word still waits.
module byte_run_length_encoder #(
  parameter int unsigned MAX_RUN        = brle_pkg::MAX_RUN_DEF,
  parameter int unsigned BYTES_PER_WORD = brle_pkg::BPW_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  brle_stream_if.sink   in_i,
  brle_stream_if.source out_o
);
  import brle_pkg::*;

  localparam int unsigned CntW    = $clog2(BYTES_PER_WORD + 1);
  localparam int unsigned AccW    = 8 * BYTES_PER_WORD;
  localparam logic [7:0]  MaxRunB = 8'(MAX_RUN);
  localparam logic [CntW-1:0] FullCnt = CntW'(BYTES_PER_WORD);

  // Sequencer and encoder state.
  brle_state_e       state_q, state_d;
  logic [7:0]        rv_q, rv_d;
  logic [7:0]        rc_q, rc_d;
  logic [7:0]        lc_q, lc_d;
  logic [LIT_AW-1:0] idx_q, idx_d;
  logic [7:0]        b_q, b_d;
  logic              last_q, last_d;
  logic              phase2_q, phase2_d;
  logic              ret_final_q, ret_final_d;

  // Packer state.
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  brle_out_t         out_q, out_d;

  // Literal memory.
  logic [7:0]        lit_mem [LIT_DEPTH];
  logic [7:0]        rd_data_q;
  logic [LIT_AW-1:0] rd_addr;
  logic              mem_we;

  // Handshakes between the sequencer and the packer.
  logic              push_v;
  logic [7:0]        push_byte;
  logic              push_ok;
  logic              send_v;
  logic              send_ok;
  logic              out_free;
  logic              in_fire;
  logic              extend;
  logic              close_done;
  logic              flush_end;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;
  assign push_ok  = (cnt_q != FullCnt) | out_free;
  assign send_ok  = out_free;
  assign extend   = (rc_q != 8'd0) && (in_i.data.pixel_byte == rv_q) && (rc_q < MaxRunB);
  assign flush_end = ({1'b0, idx_q} == (lc_q - 8'd1));

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Sequencer: next state and the encoder state updates.
  always_comb begin
    state_d     = state_q;
    rv_d        = rv_q;
    rc_d        = rc_q;
    lc_d        = lc_q;
    idx_d       = idx_q;
    b_d         = b_q;
    last_d      = last_q;
    phase2_d    = phase2_q;
    ret_final_d = ret_final_q;
    push_v      = 1'b0;
    push_byte   = 8'h00;
    send_v      = 1'b0;
    mem_we      = 1'b0;
    close_done  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          b_d      = in_i.data.pixel_byte;
          last_d   = in_i.data.stream_last;
          phase2_d = 1'b0;
          if (extend) begin
            rc_d = rc_q + 8'd1;
            if (in_i.data.stream_last) begin
              phase2_d = 1'b1;
              state_d  = ST_CLOSE;
            end
          end else begin
            state_d = ST_CLOSE;
          end
        end
      end

      // Close the open run: a single byte goes to the literal memory, a longer run is a repeat.
      ST_CLOSE: begin
        if (rc_q == 8'd1) begin
          if (lc_q >= MaxRunB) begin
            ret_final_d = 1'b0;
            state_d     = ST_FL_HDR;
          end else begin
            mem_we     = 1'b1;
            lc_d       = lc_q + 8'd1;
            close_done = 1'b1;
          end
        end else if (rc_q >= 8'd2) begin
          if (lc_q != 8'd0) begin
            ret_final_d = 1'b0;
            state_d     = ST_FL_HDR;
          end else begin
            state_d = ST_RPT_HDR;
          end
        end else begin
          close_done = 1'b1;
        end
      end

      ST_RPT_HDR: begin
        push_v    = 1'b1;
        push_byte = RPT_FLAG | (rc_q - 8'd1);
        if (push_ok) begin
          state_d = ST_RPT_VAL;
        end
      end

      ST_RPT_VAL: begin
        push_v    = 1'b1;
        push_byte = rv_q;
        if (push_ok) begin
          close_done = 1'b1;
        end
      end

      // End of stream: flush what is left and return to the reset state.
      ST_FINAL: begin
        if (lc_q != 8'd0) begin
          ret_final_d = 1'b1;
          state_d     = ST_FL_HDR;
        end else begin
          rv_d    = 8'd0;
          rc_d    = 8'd0;
          state_d = ST_DONE;
        end
      end

      ST_FL_HDR: begin
        push_v    = 1'b1;
        push_byte = LIT_FLAG | (lc_q - 8'd1);
        if (push_ok) begin
          state_d = ST_FL_DATA;
        end
      end

      ST_FL_DATA: begin
        push_v    = 1'b1;
        push_byte = rd_data_q;
        if (push_ok) begin
          if (flush_end) begin
            lc_d    = 8'd0;
            idx_d   = '0;
            state_d = ret_final_q ? ST_FINAL : ST_CLOSE;
          end else begin
            idx_d = idx_q + LIT_AW'(1);
          end
        end
      end

      ST_DONE: begin
        if (cnt_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          send_v = 1'b1;
          if (send_ok) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // After a run is closed: open the new run, or go on to the end-of-stream flush.
    if (close_done) begin
      if (!phase2_q) begin
        rv_d = b_q;
        rc_d = 8'd1;
        if (last_q) begin
          phase2_d = 1'b1;
          state_d  = ST_CLOSE;
        end else begin
          state_d = (cnt_q != '0) ? ST_DONE : ST_IDLE;
        end
      end else begin
        rc_d    = 8'd0;
        state_d = ST_FINAL;
      end
    end
  end

  // Word packer: gathers bytes and hands full or final words to the output register.
  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (push_v && push_ok) begin
      if (cnt_q == FullCnt) begin
        out_d.packed_bytes = 64'(acc_q);
        out_d.byte_count   = 4'(cnt_q);
        out_d.group_last   = 1'b0;
        out_d.stream_end   = 1'b0;
        out_valid_d        = 1'b1;
        acc_d              = AccW'(push_byte);
        cnt_d              = CntW'(1);
      end else begin
        for (int i = 0; i < int'(BYTES_PER_WORD); i++) begin
          if (cnt_q == CntW'(i)) begin
            acc_d[8*i +: 8] = push_byte;
          end
        end
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (send_v && send_ok) begin
      out_d.packed_bytes = 64'(acc_q);
      out_d.byte_count   = 4'(cnt_q);
      out_d.group_last   = 1'b1;
      out_d.stream_end   = last_q;
      out_valid_d        = 1'b1;
      acc_d              = '0;
      cnt_d              = '0;
    end
  end

  // Read address of the literal memory: it moves ahead as soon as a stored byte is taken.
  always_comb begin
    rd_addr = idx_q;
    if ((state_q == ST_FL_DATA) && push_ok) begin
      rd_addr = idx_q + LIT_AW'(1);
    end
  end

  // Literal memory with one write and one registered read port. A write happens only while a
  // run is closed, before any flush reads it, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lit_mem[lc_q[LIT_AW-1:0]] <= rv_q;
    end
    rd_data_q <= lit_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rv_q        <= 8'd0;
      rc_q        <= 8'd0;
      lc_q        <= 8'd0;
      idx_q       <= '0;
      phase2_q    <= 1'b0;
      ret_final_q <= 1'b0;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      rc_q        <= rc_d;
      lc_q        <= lc_d;
      idx_q       <= idx_d;
      phase2_q    <= phase2_d;
      ret_final_q <= ret_final_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    b_q    <= b_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  // The literal memory never holds more than one full group.
  assert property (@(posedge clk_i) disable iff (!rst_ni) lc_q <= MaxRunB)
    else $error("literal count exceeds the run cap");

  // A waiting word always carries between one and a full word of bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.byte_count != 4'd0) && (out_q.byte_count <= 4'(BYTES_PER_WORD)))
    else $error("output word with an invalid byte count");

  // The final word of a stream is also the last word of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.stream_end) |-> out_q.group_last)
    else $error("stream end without group end");

  // Between streams no literals are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && rc_q == 8'd0) |-> (lc_q == 8'd0))
    else $error("literals pending with no open run");

endmodule

### tb/byte_run_length_encoder_tb.sv
// Testbench of the byte run-length encoder: stream driver, word monitor and encoding predictor.
module byte_run_length_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brle_pkg::*;

  localparam int unsigned RUN_CAP      = MAX_RUN_DEF;
  localparam int unsigned WORD_BYTES   = BPW_DEF;
  localparam int unsigned RANDOM_ITEMS = 20;
  localparam int unsigned CALM_ITEMS   = 20;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;

  // Shapes of generated byte streams.
  typedef enum int {
    SHAPE_MIXED,
    SHAPE_LONG_RUN,
    SHAPE_LONG_LIT
  } stream_shape_e;

  logic clk_i;
  logic rst_ni;

  brle_stream_if #(.T(brle_in_t))  in_if ();
  brle_stream_if #(.T(brle_out_t)) out_if ();

  byte_run_length_encoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Bytes waiting to be sent and encoded words waiting to arrive.
  brle_in_t    pending_bytes[$];
  brle_out_t   expected_words[$];
  int unsigned queued_items;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  // Idling controls shared between the stimulus and the drivers.
  bit          calm;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit          in_took;

  // Encoder state as the predictor sees it.
  logic [7:0]  run_val;
  int unsigned run_len;
  logic [7:0]  lit_mem [LIT_DEPTH];
  int unsigned lit_cnt;
  logic [7:0]  enc_bytes[$];

  // Emit the pending literals as one group with its header.
  function automatic void flush_literals();
    if (lit_cnt == 0) return;
    enc_bytes.push_back(LIT_FLAG | 8'(lit_cnt - 1));
    for (int i = 0; i < int'(lit_cnt); i++) enc_bytes.push_back(lit_mem[i]);
    lit_cnt = 0;
  endfunction

  // Close the open run: a single byte joins the literals, a longer run becomes a repeat.
  function automatic void close_run();
    if (run_len == 1) begin
      if (lit_cnt >= RUN_CAP) flush_literals();
      lit_mem[lit_cnt % LIT_DEPTH] = run_val;
      lit_cnt++;
    end else if (run_len >= 2) begin
      flush_literals();
      enc_bytes.push_back(RPT_FLAG | 8'(run_len - 1));
      enc_bytes.push_back(run_val);
    end
    run_len = 0;
  endfunction

  // Encode one accepted byte and queue the words that it produces.
  function automatic void encode_byte(logic [7:0] pix, logic last);
    int unsigned nwords;
    int unsigned cnt;
    brle_out_t   w;
    enc_bytes.delete();
    if (run_len > 0 && pix == run_val && run_len < RUN_CAP) begin
      run_len++;
    end else begin
      close_run();
      run_val = pix;
      run_len = 1;
    end
    if (last) begin
      close_run();
      flush_literals();
    end
    nwords = (enc_bytes.size() + WORD_BYTES - 1) / WORD_BYTES;
    for (int k = 0; k < int'(nwords); k++) begin
      cnt = enc_bytes.size() - k * WORD_BYTES;
      if (cnt > WORD_BYTES) cnt = WORD_BYTES;
      w = '0;
      for (int i = 0; i < int'(cnt); i++) w.packed_bytes[8*i +: 8] = enc_bytes[k*WORD_BYTES + i];
      w.byte_count = 4'(cnt);
      w.group_last = (k == int'(nwords) - 1);
      w.stream_end = (k == int'(nwords) - 1) && last;
      expected_words.push_back(w);
    end
    if (last) begin
      run_val = '0;
      run_len = 0;
      lit_cnt = 0;
    end
  endfunction

  function automatic void report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Compare an arriving word with the oldest expected one.
  function automatic void check_word(brle_out_t got);
    brle_out_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, got %h/%0d/%b/%b", $time,
               got.packed_bytes, got.byte_count, got.group_last, got.stream_end);
      mismatch_count++;
      return;
    end
    want = expected_words.pop_front();
    report_field("packed_bytes", want.packed_bytes, got.packed_bytes);
    report_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
    report_field("group_last", 64'(want.group_last), 64'(got.group_last));
    report_field("stream_end", 64'(want.stream_end), 64'(got.stream_end));
  endfunction

  function automatic void add_byte(logic [7:0] v, logic last);
    brle_in_t it;
    it.pixel_byte  = v;
    it.stream_last = last;
    pending_bytes.push_back(it);
    queued_items++;
  endfunction

  // Build one stream of the given shape; the final byte carries the end marker.
  function automatic void add_stream(stream_shape_e shape);
    logic [7:0]  q[$];
    logic [7:0]  v;
    int unsigned n;
    int unsigned target;
    case (shape)
      SHAPE_LONG_RUN: begin
        v = 8'($urandom);
        n = $urandom_range(RUN_CAP + 1, RUN_CAP + 3);
        repeat (n) q.push_back(v);
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
      end
      SHAPE_LONG_LIT: begin
        v = 8'($urandom);
        n = $urandom_range(RUN_CAP + 1, RUN_CAP + 4);
        repeat (n) begin
          v = v + 8'($urandom_range(1, 255));
          q.push_back(v);
        end
        // Sometimes end on a repeat so that a full literal group is flushed before it.
        if ($urandom_range(0, 1) == 1) repeat (2) q.push_back(v + 8'd1);
      end
      default: begin
        target = $urandom_range(1, 24);
        while (q.size() < target) begin
          case ($urandom_range(0, 3))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = (q.size() > 0) ? q[$] : 8'($urandom);
            default: v = 8'($urandom);
          endcase
          case ($urandom_range(0, 19))
            0, 1, 2:                n = $urandom_range(5, 20);
            3, 4, 5, 6, 7:          n = $urandom_range(2, 4);
            default:                n = 1;
          endcase
          repeat (n) q.push_back(v);
        end
      end
    endcase
    for (int i = 0; i < q.size(); i++) add_byte(q[i], i == q.size() - 1);
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 40;
    endcase
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Input driver: presents queued bytes at the falling edge, with idle bursts.
  always @(negedge clk_i) begin
    logic     nxt_valid;
    brle_in_t nxt_data;
    nxt_valid = in_if.valid;
    nxt_data  = in_if.data;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!in_if.valid || in_took) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_bytes.size() > 0) begin
        if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 13);
        end else begin
          nxt_valid = 1'b1;
          nxt_data  = pending_bytes.pop_front();
        end
      end
    end
    in_took = 1'b0;
    in_if.valid <= nxt_valid;
    in_if.data  <= nxt_data;
  end

  // Output side: ready with random stall bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap = $urandom_range(0, 13);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted byte, checks each accepted word, watches for stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        encode_byte(in_if.data.pixel_byte, in_if.data.stream_last);
        in_took = 1'b1;
      end
      if (out_if.valid && out_if.ready) check_word(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned start_items;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    run_val        = '0;
    run_len        = 0;
    lit_cnt        = 0;
    queued_items   = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    calm           = 1'b0;
    send_gap       = 0;
    recv_gap       = 0;
    in_took        = 1'b0;
    send_idle_pct  = 20;
    recv_idle_pct  = 20;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed streams: single-byte streams at both extremes, a run of two,
    // literals flushed ahead of a repeat, and a repeat followed by a literal.
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hA5, 1'b0);
    add_byte(8'hA5, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h55, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);

    // Hold off until the block has delivered everything so far.
    while (pending_bytes.size() != 0 || in_if.valid || expected_words.size() != 0)
      @(posedge clk_i);

    // Random part: the run cap and the full literal store first, then a few mixed streams.
    add_stream(SHAPE_LONG_RUN);
    add_stream(SHAPE_LONG_LIT);
    start_items = queued_items;
    while (queued_items - start_items < RANDOM_ITEMS) begin
      while (pending_bytes.size() > 4) @(posedge clk_i);
      send_idle_pct = pick_idle_pct();
      recv_idle_pct = pick_idle_pct();
      add_stream(SHAPE_MIXED);
    end

    // Last stretch runs without idling on either side.
    while (pending_bytes.size() != 0) @(posedge clk_i);
    calm     = 1'b1;
    send_gap = 0;
    recv_gap = 0;
    start_items = queued_items;
    while (queued_items - start_items < CALM_ITEMS) add_stream(SHAPE_MIXED);

    while (pending_bytes.size() != 0 || in_if.valid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### byte_run_length_encoder.f
design/brle_pkg.sv
design/brle_stream_if.sv
design/byte_run_length_encoder.sv
tb/byte_run_length_encoder_tb.sv
